>>> src/twr_pkg.sv
// Shared types and constants for the two-way ranging responder.
// No dependencies; every other file of the block imports this package.
package twr_pkg;

  localparam int unsigned StampW = 40;
  localparam int unsigned RespW  = 41;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_MY_ADDR       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BCAST_ADDR    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REPLY_DELAY   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ANT_DELAY     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_POLL_TYPE     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FINAL_TYPE    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MIN_FRAME_LEN = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MIN_FINAL_LEN = 3'd7;

  // The transmit word keeps only even values before it is shifted back.
  localparam logic [31:0] TX_WORD_MASK = 32'hFFFF_FFFE;
  localparam int unsigned TX_SHIFT     = 8;

  typedef enum logic [2:0] {
    EV_BAD   = 3'd0,
    EV_OTHER = 3'd1,
    EV_SCHED = 3'd2,
    EV_LATE  = 3'd3,
    EV_FINAL = 3'd4
  } event_kind_e;

  typedef struct packed {
    logic              rx_ok;
    logic [6:0]        frame_len;
    logic [15:0]       dst_addr;
    logic [15:0]       src_addr;
    logic [7:0]        seq_num;
    logic [7:0]        msg_type;
    logic [StampW-1:0] rx_stamp;
    logic              tx_failed;
  } rx_item_t;

  typedef struct packed {
    logic [2:0]        event_kind;
    logic [31:0]       tx_time;
    logic [RespW-1:0]  resp_tx_stamp;
    logic [StampW-1:0] poll_rx_stamp;
    logic [StampW-1:0] final_rx_stamp;
    logic [15:0]       reply_dst;
    logic [7:0]        reply_seq;
    logic              stamp_zero;
    logic [CntW-1:0]   reply_count;
    logic [CntW-1:0]   bad_count;
    logic [CntW-1:0]   late_count;
    logic [CntW-1:0]   final_count;
  } ev_item_t;

  typedef struct packed {
    logic [15:0]       my_addr;
    logic [15:0]       bcast_addr;
    logic [StampW-1:0] scaled_delay;
    logic [15:0]       ant_delay;
    logic [7:0]        poll_type;
    logic [7:0]        final_type;
    logic [6:0]        min_frame_len;
    logic [6:0]        min_final_len;
  } cfg_t;

  typedef struct packed {
    logic              ranging_open;
    logic [7:0]        ranging_seq;
    logic [StampW-1:0] poll_stamp;
    logic [RespW-1:0]  resp_stamp;
    logic [CntW-1:0]   replies;
    logic [CntW-1:0]   bads;
    logic [CntW-1:0]   lates;
    logic [CntW-1:0]   finals_seen;
  } state_t;

endpackage

>>> src/twr_rx_if.sv
// Received-frame channel: valid/ready handshake with one frame request.
// Depends on twr_pkg for the payload type.
interface twr_rx_if
  import twr_pkg::*;
();
  logic     valid;
  logic     ready;
  rx_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/twr_ev_if.sv
// Event channel: valid/ready handshake with one ranging event request.
// Depends on twr_pkg for the payload type.
interface twr_ev_if
  import twr_pkg::*;
();
  logic     valid;
  logic     ready;
  ev_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/twr_cfg.sv
// Configuration register file of the ranging responder.
// Depends on twr_pkg; the reply delay is stored already scaled to timestamp units.
module twr_cfg
  import twr_pkg::*;
#(
  parameter int unsigned UUS_SCALE = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] wdata_i,
  output cfg_t                cfg_o
);

  localparam int unsigned ScaleW = $clog2(UUS_SCALE + 1);
  localparam int unsigned ProdW  = CfgDataW + ScaleW;

  cfg_t             cfg_q, cfg_d;
  logic [ProdW-1:0] prod;

  // Constant multiply, done once per write instead of per frame.
  assign prod = ProdW'(wdata_i) * ProdW'(UUS_SCALE);

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        REG_MY_ADDR:       cfg_d.my_addr       = wdata_i;
        REG_BCAST_ADDR:    cfg_d.bcast_addr    = wdata_i;
        REG_REPLY_DELAY:   cfg_d.scaled_delay  = StampW'(prod);
        REG_ANT_DELAY:     cfg_d.ant_delay     = wdata_i;
        REG_POLL_TYPE:     cfg_d.poll_type     = wdata_i[7:0];
        REG_FINAL_TYPE:    cfg_d.final_type    = wdata_i[7:0];
        REG_MIN_FRAME_LEN: cfg_d.min_frame_len = wdata_i[6:0];
        REG_MIN_FINAL_LEN: cfg_d.min_final_len = wdata_i[6:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.my_addr       <= '0;
      cfg_q.bcast_addr    <= 16'hFFFF;
      cfg_q.scaled_delay  <= '0;
      cfg_q.ant_delay     <= '0;
      cfg_q.poll_type     <= 8'd1;
      cfg_q.final_type    <= 8'd3;
      cfg_q.min_frame_len <= '0;
      cfg_q.min_final_len <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/twr_core.sv
// Frame screening and response scheduling logic, purely combinational.
// Depends on twr_pkg; takes one frame, the configuration and the ranging state.
module twr_core
  import twr_pkg::*;
(
  input  rx_item_t item_i,
  input  cfg_t     cfg_i,
  input  state_t   st_i,
  output state_t   st_o,
  output ev_item_t ev_o
);

  logic [StampW-1:0] sum;
  logic [31:0]       tx_word;
  logic [RespW-1:0]  resp;
  logic              addr_hit;
  event_kind_e       kind;

  assign sum      = item_i.rx_stamp + cfg_i.scaled_delay;
  assign tx_word  = sum[StampW-1:TX_SHIFT];
  assign resp     = (RespW'(tx_word & TX_WORD_MASK) << TX_SHIFT) + RespW'(cfg_i.ant_delay);
  assign addr_hit = (item_i.dst_addr == cfg_i.my_addr) ||
                    (item_i.dst_addr == cfg_i.bcast_addr);

  always_comb begin
    st_o = st_i;
    kind = EV_OTHER;
    ev_o = '0;

    if (!item_i.rx_ok || (item_i.frame_len < cfg_i.min_frame_len)) begin
      kind    = EV_BAD;
      st_o.bads = st_i.bads + 1'b1;
    end else if (!addr_hit) begin
      kind = EV_OTHER;
    end else if (item_i.msg_type == cfg_i.final_type) begin
      if (item_i.frame_len < cfg_i.min_final_len) begin
        kind      = EV_BAD;
        st_o.bads = st_i.bads + 1'b1;
      end else if (!st_i.ranging_open || (item_i.seq_num != st_i.ranging_seq)) begin
        kind = EV_OTHER;
      end else begin
        kind                = EV_FINAL;
        ev_o.final_rx_stamp = item_i.rx_stamp;
        ev_o.stamp_zero     = (item_i.rx_stamp == '0);
        st_o.finals_seen    = st_i.finals_seen + 1'b1;
        st_o.ranging_open   = 1'b0;
      end
    end else if (item_i.msg_type != cfg_i.poll_type) begin
      kind      = EV_BAD;
      st_o.bads = st_i.bads + 1'b1;
    end else begin
      // A late poll still records both stamps but leaves the open cycle alone.
      ev_o.tx_time    = tx_word;
      ev_o.reply_dst  = item_i.src_addr;
      ev_o.reply_seq  = item_i.seq_num;
      st_o.poll_stamp = item_i.rx_stamp;
      st_o.resp_stamp = resp;
      if (item_i.tx_failed) begin
        kind       = EV_LATE;
        st_o.lates = st_i.lates + 1'b1;
      end else begin
        kind              = EV_SCHED;
        st_o.ranging_seq  = item_i.seq_num;
        st_o.ranging_open = 1'b1;
        st_o.replies      = st_i.replies + 1'b1;
      end
    end

    ev_o.event_kind    = kind;
    ev_o.resp_tx_stamp = st_o.resp_stamp;
    ev_o.poll_rx_stamp = st_o.poll_stamp;
    ev_o.reply_count   = st_o.replies;
    ev_o.bad_count     = st_o.bads;
    ev_o.late_count    = st_o.lates;
    ev_o.final_count   = st_o.finals_seen;
  end

endmodule

>>> src/twr_responder_step.sv
// Top level of the two-way ranging responder: frame register, core, event register.
// Depends on twr_pkg, twr_rx_if, twr_ev_if, twr_cfg and twr_core.
//
//   Port       Dir  Handshake     Moves
//   rx_i       in   valid/ready   one received-frame request
//   ev_o       out  valid/ready   one ranging event request per frame
//   cfg_*_i    in   write enable  one configuration register
//
// An accepted frame waits in the frame register until the event register is free;
// its event is then loaded into the event register, which offers it on ev_o.
// A new frame can be accepted in every cycle while the event sink keeps taking
// events; the single core between the two registers sets the rate of one frame
// per clock.
// Reset clears the valid flags, the counters, the ranging cycle state and the
// configuration to its documented defaults.
// When the event sink stalls, the frame register holds its frame, and rx_i
// ready falls only once both registers are full.
module twr_responder_step
  import twr_pkg::*;
#(
  parameter int unsigned UUS_SCALE = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  twr_rx_if.sink              rx_i,
  twr_ev_if.source            ev_o
);

  cfg_t     cfg;
  state_t   st_q, st_d;
  rx_item_t item_q;
  logic     item_vld_q;
  ev_item_t ev_q, ev_d;
  logic     ev_vld_q;
  logic     advance;
  logic     take;

  twr_cfg #(
    .UUS_SCALE(UUS_SCALE)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  twr_core u_core (
    .item_i (item_q),
    .cfg_i  (cfg),
    .st_i   (st_q),
    .st_o   (st_d),
    .ev_o   (ev_d)
  );

  // The held frame moves on, and updates the ranging state, only when the
  // event register is empty or being emptied in this cycle.
  assign advance    = item_vld_q && (!ev_vld_q || ev_o.ready);
  assign rx_i.ready = !item_vld_q || advance;
  assign take       = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      item_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= rx_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_vld_q <= 1'b0;
      st_q     <= '0;
    end else begin
      if (advance) begin
        ev_vld_q <= 1'b1;
        st_q     <= st_d;
      end else if (ev_o.ready) begin
        ev_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_q <= ev_d;
    end
  end

  assign ev_o.valid = ev_vld_q;
  assign ev_o.data  = ev_q;

endmodule

>>> verif/twr_responder_step_tb.sv
// Testbench for twr_responder_step: directed and random received-frame requests
// checked against a built-in responder predictor. Depends on twr_pkg, twr_rx_if,
// twr_ev_if and the responder RTL; needs no files or arguments at run time.
`timescale 1ns / 1ps

module twr_responder_step_tb;
  import twr_pkg::*;

  localparam int unsigned UUS_SCALE        = 65536;
  // Two register stages sit between a frame and its event; a few spare cycles
  // are allowed before the configuration is touched or the run ends.
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned FRAMES_PER_PHASE = 200;
  // The receiver stops taking events for a long stretch once this many have
  // arrived, so that both register stages fill and rx ready falls.
  localparam int unsigned HOLD_AFTER       = 300;
  localparam int unsigned HOLD_CYCLES      = 120;
  localparam int unsigned MAX_PRINTED      = 40;
  localparam int unsigned TIMEOUT_NS       = 2_000_000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  twr_rx_if rx_if ();
  twr_ev_if ev_if ();

  twr_responder_step #(
    .UUS_SCALE (UUS_SCALE)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .rx_i        (rx_if),
    .ev_o        (ev_if)
  );

  // Shadow copy of the configuration registers, starting at their reset values.
  logic [15:0] my_addr       = 16'h0000;
  logic [15:0] bcast_addr    = 16'hFFFF;
  logic [15:0] reply_delay   = 16'h0000;
  logic [15:0] ant_delay     = 16'h0000;
  logic [7:0]  poll_type     = 8'd1;
  logic [7:0]  final_type    = 8'd3;
  logic [6:0]  min_frame_len = 7'd0;
  logic [6:0]  min_final_len = 7'd0;

  // Predicted ranging state: open cycle, stored stamps and the four counters.
  state_t rng = '0;

  rx_item_t    pending_frames[$];
  ev_item_t    expected_events[$];

  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned frames_accepted;
  int unsigned events_seen;
  int unsigned mismatches;
  int unsigned kind_tally[8];
  int unsigned settings_used;
  logic [7:0]  gen_seq;

  logic [7:0]  stall_pat;
  logic [2:0]  pat_pos;
  logic [5:0]  pat_age;
  int unsigned hold_left;
  logic        hold_done;

  ev_item_t    want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("twr_responder_step test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Screening order: receive error or short frame is bad, a foreign
  // destination is other, then the final check (which wins when the poll and
  // final codes are equal), then any type that is not a poll is bad. A poll
  // always refreshes both stored stamps; only a poll sent on time opens a cycle.
  // ---------------------------------------------------------------------------
  function automatic ev_item_t ranging_event(input rx_item_t f);
    ev_item_t    e;
    logic [39:0] sum;
    logic [31:0] word;
    e = '0;
    if (!f.rx_ok || f.frame_len < min_frame_len) begin
      rng.bads = rng.bads + 1;
      e.event_kind = EV_BAD;
    end else if (f.dst_addr != my_addr && f.dst_addr != bcast_addr) begin
      e.event_kind = EV_OTHER;
    end else if (f.msg_type == final_type) begin
      if (f.frame_len < min_final_len) begin
        rng.bads = rng.bads + 1;
        e.event_kind = EV_BAD;
      end else if (!rng.ranging_open || f.seq_num != rng.ranging_seq) begin
        e.event_kind = EV_OTHER;
      end else begin
        e.event_kind     = EV_FINAL;
        e.final_rx_stamp = f.rx_stamp;
        e.stamp_zero     = (f.rx_stamp == '0);
        rng.finals_seen  = rng.finals_seen + 1;
        rng.ranging_open = 1'b0;
      end
    end else if (f.msg_type != poll_type) begin
      rng.bads = rng.bads + 1;
      e.event_kind = EV_BAD;
    end else begin
      // The delay sum wraps at 40 bits before it is shifted down.
      sum  = f.rx_stamp + 40'(64'(reply_delay) * UUS_SCALE);
      word = sum[39:TX_SHIFT];
      rng.poll_stamp = f.rx_stamp;
      rng.resp_stamp = (RespW'(word & TX_WORD_MASK) << TX_SHIFT) + RespW'(ant_delay);
      e.tx_time   = word;
      e.reply_dst = f.src_addr;
      e.reply_seq = f.seq_num;
      if (f.tx_failed) begin
        // A late response leaves any open cycle and its sequence alone.
        rng.lates = rng.lates + 1;
        e.event_kind = EV_LATE;
      end else begin
        rng.ranging_seq  = f.seq_num;
        rng.ranging_open = 1'b1;
        rng.replies      = rng.replies + 1;
        e.event_kind     = EV_SCHED;
      end
    end
    e.resp_tx_stamp = rng.resp_stamp;
    e.poll_rx_stamp = rng.poll_stamp;
    e.reply_count   = rng.replies;
    e.bad_count     = rng.bads;
    e.late_count    = rng.lates;
    e.final_count   = rng.finals_seen;
    return e;
  endfunction

  function automatic rx_item_t mk_frame(input logic ok, input logic [6:0] len,
                                        input logic [15:0] dst, input logic [15:0] src,
                                        input logic [7:0] seq, input logic [7:0] typ,
                                        input logic [39:0] stamp, input logic failed);
    rx_item_t f;
    f.rx_ok     = ok;
    f.frame_len = len;
    f.dst_addr  = dst;
    f.src_addr  = src;
    f.seq_num   = seq;
    f.msg_type  = typ;
    f.rx_stamp  = stamp;
    f.tx_failed = failed;
    return f;
  endfunction

  function automatic logic [39:0] random_stamp();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return 40'hFF_FFFF_FFFF - 40'($urandom_range(255, 0));
      default: return raw[39:0];
    endcase
  endfunction

  // Mostly well-formed poll/final exchanges addressed to this anchor, with the
  // final usually echoing the last poll's sequence; the rest is broken frames.
  function automatic rx_item_t random_frame();
    rx_item_t    f;
    logic [6:0]  lo;
    logic [127:0] raw;
    int unsigned pick;
    f.rx_ok     = 1'b1;
    f.src_addr  = 16'($urandom());
    f.seq_num   = 8'($urandom());
    f.rx_stamp  = random_stamp();
    f.tx_failed = ($urandom_range(6, 0) == 0);
    f.dst_addr  = $urandom_range(1, 0) ? my_addr : bcast_addr;
    f.msg_type  = poll_type;
    f.frame_len = 7'($urandom_range(127, min_frame_len));
    pick = $urandom_range(99, 0);
    if (pick < 40) begin
      gen_seq = f.seq_num;
    end else if (pick < 72) begin
      lo = (min_final_len > min_frame_len) ? min_final_len : min_frame_len;
      f.msg_type  = final_type;
      f.frame_len = 7'($urandom_range(127, lo));
      if ($urandom_range(4, 0) != 0) f.seq_num = gen_seq;
      if ($urandom_range(11, 0) == 0) f.rx_stamp = '0;
    end else begin
      case ($urandom_range(5, 0))
        0: begin
          raw = {$urandom(), $urandom(), $urandom(), $urandom()};
          f = raw[$bits(rx_item_t)-1:0];
        end
        1: f.rx_ok = 1'b0;
        2: begin
          if (min_frame_len != 0) f.frame_len = 7'($urandom_range(min_frame_len - 1, 0));
          else f.rx_ok = 1'b0;
        end
        3: begin
          f.dst_addr = 16'($urandom());
          while (f.dst_addr == my_addr || f.dst_addr == bcast_addr)
            f.dst_addr = f.dst_addr + 1;
        end
        4: begin
          f.msg_type = 8'($urandom());
          while (f.msg_type == poll_type || f.msg_type == final_type)
            f.msg_type = f.msg_type + 1;
        end
        default: begin
          f.msg_type = final_type;
          if (min_final_len > min_frame_len)
            f.frame_len = 7'($urandom_range(min_final_len - 1, min_frame_len));
          else f.rx_ok = 1'b0;
        end
      endcase
    end
    return f;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("[%0t] MISMATCH event %0d: %s", $time, events_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp_val));
  endtask

  // One register write; the shadow follows with the register's own width, so
  // the upper bits of the data bus are junk for the narrow registers.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_MY_ADDR:       my_addr       = val;
      REG_BCAST_ADDR:    bcast_addr    = val;
      REG_REPLY_DELAY:   reply_delay   = val;
      REG_ANT_DELAY:     ant_delay     = val;
      REG_POLL_TYPE:     poll_type     = val[7:0];
      REG_FINAL_TYPE:    final_type    = val[7:0];
      REG_MIN_FRAME_LEN: min_frame_len = val[6:0];
      REG_MIN_FINAL_LEN: min_final_len = val[6:0];
      default: ;
    endcase
  endtask

  // Waits until every queued frame went in and every event came out, then
  // lets the pipeline settle before the configuration may change.
  task automatic drain_frames();
    do @(negedge clk);
    while (pending_frames.size() != 0 || rx_if.valid || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Frame driver: offers queued frames in bursts of random length separated by
  // random gaps; about a third of the bursts have no gap after them, which gives
  // long back-to-back stretches. The prediction is made at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_if.valid <= 1'b0;
      rx_if.data  <= '0;
      gap_left    <= 0;
      burst_left  <= 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        expected_events.push_back(ranging_event(rx_if.data));
        frames_accepted++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          rx_if.valid <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          rx_if.valid <= 1'b1;
          rx_if.data  <= pending_frames.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(24, 1);
            gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(7, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Event receiver: ready follows an 8-bit pattern that is redrawn whenever the 6-bit
  // age counter wraps (always ready, sparse, or random), plus one long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      ev_if.ready <= 1'b0;
      stall_pat   <= 8'hFF;
      pat_pos     <= '0;
      pat_age     <= '0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && events_seen >= HOLD_AFTER) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      ev_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      ev_if.ready <= 1'b0;
    end else begin
      ev_if.ready <= stall_pat[pat_pos];
      pat_pos     <= pat_pos + 1;
      pat_age     <= pat_age + 1;
      if (pat_age == '1) begin
        case ($urandom_range(3, 0))
          0:       stall_pat <= 8'hFF;
          1:       stall_pat <= 8'h01;
          default: stall_pat <= 8'($urandom()) | 8'h01;
        endcase
      end
    end
  end

  // Event monitor: every accepted event is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && ev_if.valid && ev_if.ready) begin
      events_seen <= events_seen + 1;
      kind_tally[ev_if.data.event_kind]++;
      if (expected_events.size() == 0) begin
        report_mismatch("event arrived with no frame outstanding");
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", ev_if.data.event_kind, want.event_kind);
        check_field("tx_time", ev_if.data.tx_time, want.tx_time);
        check_field("resp_tx_stamp", ev_if.data.resp_tx_stamp, want.resp_tx_stamp);
        check_field("poll_rx_stamp", ev_if.data.poll_rx_stamp, want.poll_rx_stamp);
        check_field("final_rx_stamp", ev_if.data.final_rx_stamp, want.final_rx_stamp);
        check_field("reply_dst", ev_if.data.reply_dst, want.reply_dst);
        check_field("reply_seq", ev_if.data.reply_seq, want.reply_seq);
        check_field("stamp_zero", ev_if.data.stamp_zero, want.stamp_zero);
        check_field("reply_count", ev_if.data.reply_count, want.reply_count);
        check_field("bad_count", ev_if.data.bad_count, want.bad_count);
        check_field("late_count", ev_if.data.late_count, want.late_count);
        check_field("final_count", ev_if.data.final_count, want.final_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence: directed frames at the reset configuration, at the
  // register extremes and with equal poll and final codes, then random phases
  // each with a freshly drawn configuration.
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] my_v, bc_v, dly_v, ant_v;
    logic [7:0]  pt_v, ft_v;
    logic [6:0]  mfl_v, mfi_v;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    rx_if.valid = 1'b0;
    rx_if.data  = '0;
    ev_if.ready = 1'b0;
    gen_seq     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: own address 0, broadcast FFFF, poll 1, final 3.
    settings_used = 1;
    pending_frames.push_back(mk_frame(0, 0, 16'h0000, 16'h0000, 8'h00, 8'd1, '0, 0));
    // A poll on time opens the cycle; the matching final has a zero stamp.
    pending_frames.push_back(mk_frame(1, 127, 16'h0000, 16'hFFFF, 8'h05, 8'd1, '0, 0));
    pending_frames.push_back(mk_frame(1, 0, 16'hFFFF, 16'h0000, 8'h05, 8'd3, '0, 1));
    // The cycle is closed now, so the same final is unmatched.
    pending_frames.push_back(mk_frame(1, 10, 16'h0000, 16'h0000, 8'h05, 8'd3, 40'h12345, 0));
    pending_frames.push_back(mk_frame(1, 10, 16'h1234, 16'h0000, 8'h00, 8'd1, '0, 0));
    pending_frames.push_back(mk_frame(1, 10, 16'h0000, 16'h0000, 8'h00, 8'hFF, '0, 0));
    // A late poll with no cycle open; the final after it finds nothing.
    pending_frames.push_back(mk_frame(1, 20, 16'h0000, 16'hABCD, 8'h10, 8'd1,
                                      40'hFF_FFFF_FFFF, 1));
    pending_frames.push_back(mk_frame(1, 20, 16'h0000, 16'h0000, 8'h10, 8'd3, '0, 1));
    // A late poll while a cycle is open must leave that cycle's sequence alone.
    pending_frames.push_back(mk_frame(1, 30, 16'hFFFF, 16'h1111, 8'h20, 8'd1,
                                      40'h80_0000_0001, 0));
    pending_frames.push_back(mk_frame(1, 30, 16'h0000, 16'h2222, 8'h30, 8'd1,
                                      40'h7F_FFFF_FFFF, 1));
    pending_frames.push_back(mk_frame(1, 30, 16'h0000, 16'h0000, 8'h30, 8'd3, '0, 0));
    pending_frames.push_back(mk_frame(1, 30, 16'h0000, 16'h0000, 8'h20, 8'd3,
                                      40'hFF_FFFF_FFFF, 0));
    drain_frames();

    // Register extremes: longest delays, both length floors at 127.
    settings_used++;
    write_reg(REG_MY_ADDR, 16'hFFFF);
    write_reg(REG_BCAST_ADDR, 16'h0000);
    write_reg(REG_REPLY_DELAY, 16'hFFFF);
    write_reg(REG_ANT_DELAY, 16'hFFFF);
    write_reg(REG_POLL_TYPE, 16'hA5FF);
    write_reg(REG_FINAL_TYPE, 16'hFF00);
    write_reg(REG_MIN_FRAME_LEN, 16'hFF7F);
    write_reg(REG_MIN_FINAL_LEN, 16'h807F);
    @(negedge clk);
    pending_frames.push_back(mk_frame(1, 126, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, '0, 0));
    // The delay sum overflows 40 bits here and must wrap before the shift.
    pending_frames.push_back(mk_frame(1, 127, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF,
                                      40'hFF_FFFF_FFFF, 0));
    pending_frames.push_back(mk_frame(1, 127, 16'h0000, 16'hFFFF, 8'hFF, 8'h00, 40'h1, 0));
    pending_frames.push_back(mk_frame(0, 127, 16'hFFFF, 16'h0000, 8'h00, 8'hFF, '0, 0));
    pending_frames.push_back(mk_frame(1, 127, 16'h0001, 16'h0000, 8'h00, 8'hFF, '0, 0));
    drain_frames();

    // Equal poll and final codes: such a frame is always taken as a final.
    settings_used++;
    write_reg(REG_POLL_TYPE, 16'h0055);
    write_reg(REG_FINAL_TYPE, 16'h3355);
    write_reg(REG_MIN_FRAME_LEN, 16'h0000);
    write_reg(REG_MIN_FINAL_LEN, 16'h0040);
    @(negedge clk);
    pending_frames.push_back(mk_frame(1, 63, 16'hFFFF, 16'h0000, 8'h00, 8'h55, '0, 0));
    pending_frames.push_back(mk_frame(1, 64, 16'h0000, 16'h0000, 8'h00, 8'h55, '0, 0));
    pending_frames.push_back(mk_frame(1, 64, 16'h0000, 16'h0000, 8'h00, 8'h54, '0, 0));
    drain_frames();

    // Random phases; the first uses the largest delays, the last zero delays.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settings_used++;
      my_v  = 16'($urandom());
      case ($urandom_range(2, 0))
        0:       bc_v = 16'hFFFF;
        1:       bc_v = my_v;
        default: bc_v = 16'($urandom());
      endcase
      dly_v = (ph == 0) ? 16'hFFFF : (ph == RANDOM_PHASES - 1) ? 16'h0000 : 16'($urandom());
      ant_v = (ph == 0) ? 16'hFFFF : (ph == RANDOM_PHASES - 1) ? 16'h0000 : 16'($urandom());
      pt_v  = 8'($urandom());
      ft_v  = ($urandom_range(4, 0) == 0) ? pt_v : 8'($urandom());
      mfl_v = 7'($urandom_range(40, 0));
      mfi_v = 7'($urandom_range(90, 0));
      write_reg(REG_MY_ADDR, my_v);
      write_reg(REG_BCAST_ADDR, bc_v);
      write_reg(REG_REPLY_DELAY, dly_v);
      write_reg(REG_ANT_DELAY, ant_v);
      write_reg(REG_POLL_TYPE, {8'($urandom()), pt_v});
      write_reg(REG_FINAL_TYPE, {8'($urandom()), ft_v});
      write_reg(REG_MIN_FRAME_LEN, {9'($urandom()), mfl_v});
      write_reg(REG_MIN_FINAL_LEN, {9'($urandom()), mfi_v});
      @(negedge clk);
      repeat (FRAMES_PER_PHASE) pending_frames.push_back(random_frame());
      drain_frames();
    end

    $display("Covered %0d frame requests over %0d register settings, one %0d-cycle event hold.",
             frames_accepted, settings_used, HOLD_CYCLES);
    $display("Events seen: %0d scheduled, %0d late, %0d finals matched, %0d other, %0d bad.",
             kind_tally[EV_SCHED], kind_tally[EV_LATE], kind_tally[EV_FINAL],
             kind_tally[EV_OTHER], kind_tally[EV_BAD]);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("twr_responder_step test passed");
    end else begin
      $display("twr_responder_step test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/twr_pkg.sv
src/twr_rx_if.sv
src/twr_ev_if.sv
src/twr_cfg.sv
src/twr_core.sv
src/twr_responder_step.sv
verif/twr_responder_step_tb.sv
